// ----- src/assert_macros.svh -----
// Assertion macros shared by the palette dither RTL.
// Needs a clk and rst in the scope of each use; SYNTH removes the bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- src/rpod_pkg.sv -----
// Shared types, constants and the dither pattern table for the palette dither block.
// No dependencies.
package rpod_pkg;

  localparam int CoordBits  = 12;
  localparam int LevelsW    = 9;
  localparam int SpreadW    = 16;
  localparam int ColourW    = 32;
  localparam int ProdW      = 17;   // 9x8 products
  localparam int LevelW     = 10;   // level can reach 511
  localparam int IdxW       = 18;   // level + ramp*levels
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 16;
  localparam int MidDepth   = 4;
  localparam int OutDepth   = 4;
  localparam int PaletteDepthDefault = 256;

  localparam logic [CfgIndexW-1:0] RegLevels = 2'd0;
  localparam logic [CfgIndexW-1:0] RegSpread = 2'd1;

  localparam logic ReqPixel = 1'b0;
  localparam logic ReqWrite = 1'b1;

  localparam logic [LevelsW-1:0] LevelsReset = 9'd16;
  localparam logic [SpreadW-1:0] SpreadReset = 16'd512;

  typedef struct packed {
    logic                 req_type;
    logic [7:0]           intensity;
    logic [7:0]           ramp_number;
    logic [CoordBits-1:0] pos_x;
    logic [CoordBits-1:0] pos_y;
    logic [7:0]           entry_addr;
    logic [ColourW-1:0]   entry_colour;
  } req_t;

  typedef struct packed {
    logic [ColourW-1:0] pixel_word;
    logic [7:0]         palette_index;
    logic               index_error;
  } res_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic               req_type;
    logic               index_error;
    logic [IdxW-1:0]    index;
    logic [7:0]         entry_addr;
    logic [ColourW-1:0] entry_colour;
  } mid_t;

  // 4x4 ordered dither rows; row n sets n of the 16 cells
  function automatic logic [15:0] pattern_row(input logic [3:0] row);
    logic [15:0] pat;
    begin
      case (row)
        4'd0:    pat = 16'h0000;
        4'd1:    pat = 16'h0001;
        4'd2:    pat = 16'h0401;
        4'd3:    pat = 16'h0405;
        4'd4:    pat = 16'h0505;
        4'd5:    pat = 16'h0525;
        4'd6:    pat = 16'h8525;
        4'd7:    pat = 16'h85A5;
        4'd8:    pat = 16'hA5A5;
        4'd9:    pat = 16'hA5A7;
        4'd10:   pat = 16'hADA7;
        4'd11:   pat = 16'hADAF;
        4'd12:   pat = 16'hAFAF;
        4'd13:   pat = 16'hAFEF;
        4'd14:   pat = 16'hBFEF;
        4'd15:   pat = 16'hBFFF;
        default: pat = 16'hFFFF;
      endcase
      return pat;
    end
  endfunction

endpackage

// ----- src/rpod_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpod_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/rpod_fifo.sv -----
// Small register queue, power-of-two depth, used between and after the pipelines.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rpod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_fifo_overrun, push && full, "push into full queue")
  `ASSERT_NEVER(a_fifo_count, count > CW'(DEPTH), "queue count past depth")

endmodule

// ----- src/rpod_front.sv -----
// Front pipeline: config registers, item intake and level/index computation.
// Depends on rpod_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rpod_front #(
  parameter int PALETTE_DEPTH = rpod_pkg::PaletteDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpod_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rpod_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           push,
  input  rpod_pkg::req_t                 req,
  output logic                           full,
  output logic                           mid_push,
  output rpod_pkg::mid_t                 mid_item,
  input  logic                           mid_full
);

  localparam int ProdW = rpod_pkg::ProdW;
  localparam int IdxW  = rpod_pkg::IdxW;
  localparam int LvW   = rpod_pkg::LevelW;
  localparam int NumW  = 27;
  localparam logic signed [NumW-1:0] NumOffset = 27'sd65280;
  localparam logic signed [NumW-1:0] NumTop    = 27'sd130560;

  typedef struct packed {
    logic                        req_type;
    logic [ProdW-1:0]            base;
    logic [8:0]                  plain;
    logic [3:0]                  pix_cell;
    logic [7:0]                  entry_addr;
    logic [rpod_pkg::ColourW-1:0] entry_colour;
  } carry_t;

  logic [rpod_pkg::LevelsW-1:0] levels;
  logic [rpod_pkg::SpreadW-1:0] spread;
  logic adv;
  logic v1, v2, v3, v4, v5, v6;
  carry_t c1, c2, c3, c4, c5;

  // stage 1 -> 2
  logic [rpod_pkg::LevelsW-1:0] nm1;
  logic [ProdW-1:0] prod_c, base_c, plain_c;
  logic [ProdW-1:0] prod1, prod2;
  // stage 2 -> 3
  logic [ProdW+7:0] prod257;
  logic [8:0]       q0_2;
  // stage 3 -> 4
  logic [ProdW-1:0] r0;
  logic [8:0]       q3;
  logic [7:0]       r3;
  // stage 4 -> 5
  logic signed [9:0]      dev;
  logic signed [NumW-1:0] mul_c;
  logic signed [NumW-1:0] num4;
  logic [8:0]             q4;
  // stage 5 -> 6
  logic [14:0]      ge;
  logic [3:0]       trow;
  logic [15:0]      pat;
  logic             step;
  logic [LvW-1:0]   level_c, level5;
  logic [IdxW-1:0]  idx_c;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= rpod_pkg::LevelsReset;
      spread <= rpod_pkg::SpreadReset;
    end else if (cfg_we) begin
      case (cfg_index)
        rpod_pkg::RegLevels: levels <= cfg_data[rpod_pkg::LevelsW-1:0];
        rpod_pkg::RegSpread: begin
          if (cfg_data != '0 && cfg_data < 16'd256) begin
            spread <= 16'd256;
          end else begin
            spread <= cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  assign adv      = !v6 || !mid_full;
  assign full     = !adv;
  assign mid_push = v6 && !mid_full;

  // intake multipliers
  assign nm1     = (levels == '0) ? '0 : levels - 9'd1;
  assign prod_c  = ProdW'(nm1) * ProdW'(req.intensity);
  assign base_c  = ProdW'(req.ramp_number) * ProdW'(levels);
  assign plain_c = ProdW'(levels) * ProdW'(req.intensity);

  // divide by 255: x*257>>16 is exact or one short
  assign prod257 = {prod1, 8'd0} + (ProdW+8)'(prod1);
  assign r0      = prod2 - {q0_2, 8'd0} + ProdW'(q0_2);

  // N = S*(2r-255) + 65280
  assign dev   = $signed({1'b0, r3, 1'b0}) - 10'sd255;
  assign mul_c = $signed({1'b0, spread}) * dev;

  always_comb begin
    for (int k = 0; k < 15; k++) begin
      ge[k] = num4[16:0] >= 17'((k + 1) * 8160);
    end
    trow = 4'($countones(ge));
    pat  = rpod_pkg::pattern_row(trow);
    if (num4 >= NumTop) begin
      step = 1'b1;
    end else if (num4[NumW-1]) begin
      step = 1'b0;
    end else begin
      step = pat[c4.pix_cell];
    end
    if (spread == '0) begin
      level_c = LvW'(c4.plain);
    end else begin
      level_c = LvW'(q4) + LvW'(step);
    end
  end

  assign idx_c = IdxW'(level5) + IdxW'(c5.base);

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6} <= '0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1.req_type     <= req.req_type;
      c1.base         <= base_c;
      c1.plain        <= plain_c[16:8];
      c1.pix_cell     <= {req.pos_y[1:0], req.pos_x[1:0]};
      c1.entry_addr   <= req.entry_addr;
      c1.entry_colour <= req.entry_colour;
      prod1           <= prod_c;

      c2   <= c1;
      prod2 <= prod1;
      q0_2 <= prod257[24:16];

      c3 <= c2;
      if (r0 >= ProdW'(255)) begin
        q3 <= q0_2 + 9'd1;
        r3 <= 8'(r0 - ProdW'(255));
      end else begin
        q3 <= q0_2;
        r3 <= r0[7:0];
      end

      c4   <= c3;
      q4   <= q3;
      num4 <= mul_c + NumOffset;

      c5     <= c4;
      level5 <= level_c;

      mid_item.req_type     <= c5.req_type;
      mid_item.index        <= idx_c;
      mid_item.index_error  <= idx_c >= IdxW'(PALETTE_DEPTH);
      mid_item.entry_addr   <= c5.entry_addr;
      mid_item.entry_colour <= c5.entry_colour;
    end
  end

  `ASSERT_CLK(a_stall_hold, v6 && mid_full |=> v6 && $stable(mid_item), "stalled item moved")

endmodule

// ----- src/rpod_back.sv -----
// Back end: palette RAM access and result queue.
// Depends on rpod_pkg, rpod_ram, rpod_fifo and assert_macros.svh.
`include "assert_macros.svh"
module rpod_back #(
  parameter int PALETTE_DEPTH = rpod_pkg::PaletteDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_empty,
  input  rpod_pkg::mid_t mid_item,
  output logic           mid_pop,
  output logic           empty,
  input  logic           pop,
  output rpod_pkg::res_t res
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int CW    = $clog2(rpod_pkg::OutDepth + 1);
  localparam int IdxW  = rpod_pkg::IdxW;
  localparam int ResW  = $bits(rpod_pkg::res_t);

  logic                         take;
  logic                         we;
  logic                         re;
  logic [rpod_pkg::ColourW-1:0] rdata;
  logic                         rd_v;
  logic                         rd_err;
  logic [7:0]                   rd_idx;
  logic [CW-1:0]                out_count;
  logic                         out_full;
  rpod_pkg::res_t               res_c;
  logic [ResW-1:0]              res_q;

  // credit: queue occupancy plus the read in flight
  assign take    = !mid_empty && ((out_count + CW'(rd_v)) < CW'(rpod_pkg::OutDepth));
  assign mid_pop = take;
  assign we = take && (mid_item.req_type == rpod_pkg::ReqWrite)
              && (IdxW'(mid_item.entry_addr) < IdxW'(PALETTE_DEPTH));
  assign re = take && (mid_item.req_type == rpod_pkg::ReqPixel) && !mid_item.index_error;

  rpod_ram #(
    .WIDTH (rpod_pkg::ColourW),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(mid_item.entry_addr)),
    .wdata (mid_item.entry_colour),
    .re    (re),
    .raddr (AW'(mid_item.index)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= take && (mid_item.req_type == rpod_pkg::ReqPixel);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rd_err <= mid_item.index_error;
      rd_idx <= mid_item.index[7:0];
    end
  end

  assign res_c.pixel_word    = rd_err ? '0 : rdata;
  assign res_c.palette_index = rd_idx;
  assign res_c.index_error   = rd_err;

  rpod_fifo #(
    .WIDTH (ResW),
    .DEPTH (rpod_pkg::OutDepth)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rd_v),
    .din   (res_c),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty),
    .full  (out_full),
    .count (out_count)
  );

  assign res = res_q;

  `ASSERT_NEVER(a_credit, rd_v && out_full, "result arrived with no room")

endmodule

// ----- src/ramp_palette_ordered_dither.sv -----
// Top level of the ramp palette lookup with 4x4 ordered dither.
// Depends on rpod_pkg, rpod_front, rpod_fifo and rpod_back.
//
// Use:
//  - Input queue: drive req and raise push; the item is taken on an edge with
//    push high and full low. req_type picks a pixel or a palette write.
//  - Result queue: while empty is low, res holds the oldest result; it is
//    taken on an edge with pop high. Pixel items give one result each, palette
//    writes give none. Results come out in input order.
//  - Config: cfg_we writes cfg_data into register cfg_index (0 levels per ramp,
//    1 dither spread, min 256 unless 0) at once; only while the block is idle.
// Timing: one item per cycle sustained while nothing stalls. A pixel result
//  passes six front stages (multiply, divide by 255 in two steps, spread
//  multiply, dither pick, index add), the mid queue, the palette RAM read
//  through its registered port, then the result queue that drives res.
// Stalls: a result not taken backs up the 4-deep result queue, then the
//  4-deep mid queue, then the front pipeline, and only then does full rise.
// Reset: queues empty, registers back to 16 levels and spread 512 (2.0).
//  The palette holds nothing useful until written; no clearing pass.
module ramp_palette_ordered_dither #(
  parameter int PALETTE_DEPTH = rpod_pkg::PaletteDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rpod_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rpod_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           push,
  input  rpod_pkg::req_t                 req,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output rpod_pkg::res_t                 res
);

  localparam int MidW = $bits(rpod_pkg::mid_t);

  logic                                   mid_push;
  rpod_pkg::mid_t                         mid_in;
  logic [MidW-1:0]                        mid_out;
  logic                                   mid_pop;
  logic                                   mid_empty;
  logic                                   mid_full;
  logic [$clog2(rpod_pkg::MidDepth+1)-1:0] mid_count;

  // front: config, intake, level and index maths
  rpod_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .req       (req),
    .full      (full),
    .mid_push  (mid_push),
    .mid_item  (mid_in),
    .mid_full  (mid_full)
  );

  // decouples the front pipeline from the RAM side
  rpod_fifo #(
    .WIDTH (MidW),
    .DEPTH (rpod_pkg::MidDepth)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty),
    .full  (mid_full),
    .count (mid_count)
  );

  // back: palette writes and reads, result queue
  rpod_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty || (mid_count == '0)),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

endmodule
